// ----- sv/float_to_decimal_ascii_unit_macros.svh -----
// Assertion macros for the float to decimal text unit.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef FLOAT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define FLOAT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
// same-cycle implication
`define FTDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FTDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/ftda_pkg.sv -----
// Shared types and constants of the float to decimal text unit.
// No dependencies; used by ftda_gen and float_to_decimal_ascii_unit.
package ftda_pkg;

  localparam int MAX_SIG_DIGITS = 23;

  localparam logic [6:0] INT_LAST_IDX = 7'd39;   // units digit slot
  localparam logic [6:0] FRAC_FIRST_IDX = 7'd40;
  localparam logic [6:0] DIG_LAST_IDX = 7'd111;
  localparam logic [4:0] DEF_FRAC = 5'd6;
  localparam logic [4:0] MAX_FRAC = 5'(MAX_SIG_DIGITS - 1);

  localparam logic [0:0] CFG_PREC = 1'b0;
  localparam logic [0:0] CFG_STYLE = 1'b1;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EXP = 8'h45;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct packed {
    logic       we;
    logic [6:0] addr;
    logic [3:0] data;
  } dig_wr_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_INT,
    G_FRAC
  } gen_state_t;

  typedef enum logic [3:0] {
    T_IDLE,
    T_GEN,
    T_PREP,
    T_SCRD,
    T_SCUSE,
    T_SIGN,
    T_CARRY,
    T_RD,
    T_DIG,
    T_PT,
    T_E,
    T_EMINUS,
    T_ETENS,
    T_EONES,
    T_BAD
  } top_state_t;

endpackage

// ----- sv/ftda_gen.sv -----
// Exact decimal digit generator: integer digits by repeated divide-by-ten over
// 16-bit limbs, fraction digits by multiply-by-ten over 32-bit limbs. Uses ftda_pkg.
module ftda_gen (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [30:0]      mag,
  output ftda_pkg::dig_wr_t dig_wr,
  output logic             done
);

  ftda_pkg::gen_state_t state_r, state_nxt;
  logic [127:0] ip_r, ip_nxt;
  logic [159:0] fr_r, fr_nxt;
  logic [3:0]   rem_r, rem_nxt;
  logic [3:0]   carry_r, carry_nxt;
  logic [2:0]   limb_r, limb_nxt;
  logic [6:0]   dcnt_r, dcnt_nxt;

  logic [7:0]   ef;
  logic [23:0]  m;
  logic [7:0]   sh;
  logic [276:0] v;

  logic [19:0]  icur;
  logic [35:0]  iprod;
  logic [16:0]  qest;
  logic [19:0]  rest;
  logic [15:0]  q;
  logic [3:0]   r;
  logic [35:0]  fcur;

  always_comb begin
    ef = mag[30:23];
    m = {(ef != 8'd0), mag[22:0]};
    sh = (ef != 8'd0) ? ef - 8'd1 : 8'd0;
    v = {253'd0, m} << sh;
  end

  // one limb of the long division by ten; reciprocal runs low, one fix-up
  always_comb begin
    icur = {rem_r, ip_r[127:112]};
    iprod = icur * 16'd52428;
    qest = iprod[35:19];
    rest = icur - {3'd0, qest} * 20'd10;
    if (rest >= 20'd10) begin
      q = 16'(qest + 17'd1);
      r = 4'(rest - 20'd10);
    end else begin
      q = qest[15:0];
      r = rest[3:0];
    end
    fcur = fr_r[31:0] * 36'd10 + {32'd0, carry_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftda_pkg::G_IDLE: begin
        if (load) state_nxt = ftda_pkg::G_INT;
      end
      ftda_pkg::G_INT: begin
        if (limb_r == 3'd7 && dcnt_r == 7'd0) state_nxt = ftda_pkg::G_FRAC;
      end
      ftda_pkg::G_FRAC: begin
        if (limb_r == 3'd4 && dcnt_r == ftda_pkg::DIG_LAST_IDX) state_nxt = ftda_pkg::G_IDLE;
      end
      default: state_nxt = ftda_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    dig_wr = '0;
    done = 1'b0;
    case (state_r)
      ftda_pkg::G_INT: begin
        dig_wr.we = (limb_r == 3'd7);
        dig_wr.addr = dcnt_r;
        dig_wr.data = r;
      end
      ftda_pkg::G_FRAC: begin
        dig_wr.we = (limb_r == 3'd4);
        dig_wr.addr = dcnt_r;
        dig_wr.data = fcur[24:21];
        done = (limb_r == 3'd4 && dcnt_r == ftda_pkg::DIG_LAST_IDX);
      end
      default: ;
    endcase
  end

  always_comb begin
    ip_nxt = ip_r;
    fr_nxt = fr_r;
    rem_nxt = rem_r;
    carry_nxt = carry_r;
    limb_nxt = limb_r;
    dcnt_nxt = dcnt_r;
    case (state_r)
      ftda_pkg::G_IDLE: begin
        if (load) begin
          ip_nxt = v[276:149];
          fr_nxt = {11'd0, v[148:0]};
          rem_nxt = 4'd0;
          carry_nxt = 4'd0;
          limb_nxt = 3'd0;
          dcnt_nxt = ftda_pkg::INT_LAST_IDX;
        end
      end
      ftda_pkg::G_INT: begin
        // limbs rotate through the top; eight steps restore the order
        ip_nxt = {ip_r[111:0], q};
        if (limb_r == 3'd7) begin
          rem_nxt = 4'd0;
          limb_nxt = 3'd0;
          if (dcnt_r == 7'd0) dcnt_nxt = ftda_pkg::FRAC_FIRST_IDX;
          else dcnt_nxt = dcnt_r - 7'd1;
        end else begin
          rem_nxt = r;
          limb_nxt = limb_r + 3'd1;
        end
      end
      ftda_pkg::G_FRAC: begin
        if (limb_r == 3'd4) begin
          // top limb holds 21 bits; what spills over is the digit
          fr_nxt = {11'd0, fcur[20:0], fr_r[159:32]};
          carry_nxt = 4'd0;
          limb_nxt = 3'd0;
          dcnt_nxt = dcnt_r + 7'd1;
        end else begin
          fr_nxt = {fcur[31:0], fr_r[159:32]};
          carry_nxt = fcur[35:32];
          limb_nxt = limb_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftda_pkg::G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ip_r <= ip_nxt;
    fr_r <= fr_nxt;
    rem_r <= rem_nxt;
    carry_r <= carry_nxt;
    limb_r <= limb_nxt;
    dcnt_r <= dcnt_nxt;
  end

endmodule

// ----- sv/float_to_decimal_ascii_unit.sv -----
// Top level of the float to decimal text unit: sequencer, digit memory, text out.
// Depends on ftda_pkg, ftda_gen and float_to_decimal_ascii_unit_macros.svh.
//
// Usage: write cfg_index 0 (precision, signed) and 1 (fixed style) with cfg_we
// while the unit is idle. Pulse start with in_value_bits while busy is low; the
// value is taken at that edge and busy stays high until the last character.
// Characters leave one per out_valid beat on out_char_code, out_last_char marks
// the final one. Infinity or NaN gives a single beat with out_bad_value set.
// The digit expansion runs 40 integer digits at 8 limb steps each and 72 fraction
// digits at 5 limb steps each through the divide-by-ten and multiply-by-ten limb
// datapaths of ftda_gen. A rounding scan and the text follow, each digit going
// through a read state and a use state for the registered digit memory read.
// One value is worked on at a time.
// Reset clears both registers to zero and returns the unit to idle.
// Results cannot be held off by the receiver; every beat is final.
`include "float_to_decimal_ascii_unit_macros.svh"
module float_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  output logic [7:0]  out_char_code,
  output logic        out_last_char,
  output logic        out_bad_value,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ftda_pkg::top_state_t state_r, state_nxt;
  ftda_pkg::dig_wr_t dig_wr;
  logic gen_done;
  logic gen_load;

  logic signed [7:0] prec_r;
  logic style_r;

  logic [3:0] mem [0:111];
  logic [3:0] rd_data_r;

  logic       neg_r, neg_nxt;
  logic       zero_r, zero_nxt;
  logic       fix_r, fix_nxt;
  logic [4:0] frac_r, frac_nxt;
  logic [6:0] lead_r, lead_nxt;
  logic [6:0] idx_r, idx_nxt;
  logic [6:0] dlo_r, dlo_nxt;
  logic [6:0] dhi_r, dhi_nxt;
  logic [6:0] p_r, p_nxt;
  logic       has_r, has_nxt;
  logic       rup_r, rup_nxt;
  logic       carry_r, carry_nxt;
  logic signed [7:0] ie_r, ie_nxt;

  logic       accept;
  logic       is_bad;
  logic [4:0] frac_c;
  logic [6:0] lead_clip;
  logic [6:0] pt;
  logic       exp_on;
  logic       is_rnd;
  logic       rup_c, carry_c;
  logic signed [7:0] ie_c;
  logic [5:0] ea;
  logic [13:0] eprod;
  logic [2:0] etens;
  logic [3:0] eones;
  logic [3:0] dval;

  logic       em_valid;
  logic [7:0] em_char;
  logic       em_last;
  logic       em_bad;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       out_bad_r;

  assign busy = (state_r != ftda_pkg::T_IDLE);
  assign accept = start && !busy;
  assign is_bad = (in_value_bits[30:23] == 8'hFF);
  assign gen_load = accept && !is_bad;

  ftda_gen u_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (gen_load),
    .mag    (in_value_bits[30:0]),
    .dig_wr (dig_wr),
    .done   (gen_done)
  );

  always_ff @(posedge clk) begin
    if (dig_wr.we) mem[dig_wr.addr] <= dig_wr.data;
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= 8'sd0;
      style_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ftda_pkg::CFG_PREC: prec_r <= signed'(cfg_data);
        ftda_pkg::CFG_STYLE: style_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (prec_r <= 8'sd0) frac_c = ftda_pkg::DEF_FRAC;
    else if (prec_r > signed'({3'd0, ftda_pkg::MAX_FRAC})) frac_c = ftda_pkg::MAX_FRAC;
    else frac_c = prec_r[4:0];
    lead_clip = (lead_r < ftda_pkg::INT_LAST_IDX) ? lead_r : ftda_pkg::INT_LAST_IDX;
    pt = fix_r ? ftda_pkg::INT_LAST_IDX : dlo_r;
    exp_on = !fix_r && (ie_r != 8'sd0);
    is_rnd = (idx_r == dhi_r + 7'd1);
    rup_c = (rd_data_r >= 4'd5);
    carry_c = rup_c && !has_r;
    ie_c = signed'({1'b0, ftda_pkg::INT_LAST_IDX}) - signed'({1'b0, lead_r})
           + signed'({7'd0, carry_c});
    ea = (ie_r < 8'sd0) ? 6'(-ie_r) : 6'(ie_r);
    eprod = ea * 8'd205;
    etens = eprod[13:11];
    eones = 4'(ea - {3'd0, etens} * 6'd10);
    // rounded digit: trailing nines clear, the last non-nine bumps
    if (!rup_r) dval = rd_data_r;
    else if (carry_r) dval = (!fix_r && idx_r == dlo_r) ? 4'd1 : 4'd0;
    else if (idx_r < p_r) dval = rd_data_r;
    else if (idx_r == p_r) dval = rd_data_r + 4'd1;
    else dval = 4'd0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftda_pkg::T_IDLE: begin
        if (accept) state_nxt = is_bad ? ftda_pkg::T_BAD : ftda_pkg::T_GEN;
      end
      ftda_pkg::T_GEN: begin
        if (gen_done) state_nxt = ftda_pkg::T_PREP;
      end
      ftda_pkg::T_PREP: state_nxt = ftda_pkg::T_SCRD;
      ftda_pkg::T_SCRD: state_nxt = ftda_pkg::T_SCUSE;
      ftda_pkg::T_SCUSE: begin
        if (!is_rnd) state_nxt = ftda_pkg::T_SCRD;
        else if (neg_r && !zero_r) state_nxt = ftda_pkg::T_SIGN;
        else if (fix_r && carry_c) state_nxt = ftda_pkg::T_CARRY;
        else state_nxt = ftda_pkg::T_RD;
      end
      ftda_pkg::T_SIGN: state_nxt = (fix_r && carry_r) ? ftda_pkg::T_CARRY : ftda_pkg::T_RD;
      ftda_pkg::T_CARRY: state_nxt = ftda_pkg::T_RD;
      ftda_pkg::T_RD: state_nxt = ftda_pkg::T_DIG;
      ftda_pkg::T_DIG: begin
        if (idx_r == pt) state_nxt = ftda_pkg::T_PT;
        else if (idx_r == dhi_r) state_nxt = exp_on ? ftda_pkg::T_E : ftda_pkg::T_IDLE;
        else state_nxt = ftda_pkg::T_RD;
      end
      ftda_pkg::T_PT: begin
        if (idx_r == dhi_r) state_nxt = exp_on ? ftda_pkg::T_E : ftda_pkg::T_IDLE;
        else state_nxt = ftda_pkg::T_RD;
      end
      ftda_pkg::T_E: begin
        if (ie_r < 8'sd0) state_nxt = ftda_pkg::T_EMINUS;
        else state_nxt = (ea >= 6'd10) ? ftda_pkg::T_ETENS : ftda_pkg::T_EONES;
      end
      ftda_pkg::T_EMINUS: state_nxt = (ea >= 6'd10) ? ftda_pkg::T_ETENS : ftda_pkg::T_EONES;
      ftda_pkg::T_ETENS: state_nxt = ftda_pkg::T_EONES;
      ftda_pkg::T_EONES: state_nxt = ftda_pkg::T_IDLE;
      ftda_pkg::T_BAD: state_nxt = ftda_pkg::T_IDLE;
      default: state_nxt = ftda_pkg::T_IDLE;
    endcase
  end

  // character outputs
  always_comb begin
    em_valid = 1'b0;
    em_char = ftda_pkg::CH_NUL;
    em_last = 1'b0;
    em_bad = 1'b0;
    case (state_r)
      ftda_pkg::T_SIGN: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_MINUS;
      end
      ftda_pkg::T_CARRY: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_ZERO + 8'd1;
      end
      ftda_pkg::T_DIG: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_ZERO + {4'd0, dval};
        em_last = (idx_r == dhi_r) && (idx_r != pt) && !exp_on;
      end
      ftda_pkg::T_PT: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_POINT;
        em_last = (idx_r == dhi_r) && !exp_on;
      end
      ftda_pkg::T_E: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_EXP;
      end
      ftda_pkg::T_EMINUS: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_MINUS;
      end
      ftda_pkg::T_ETENS: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_ZERO + {5'd0, etens};
      end
      ftda_pkg::T_EONES: begin
        em_valid = 1'b1;
        em_char = ftda_pkg::CH_ZERO + {4'd0, eones};
        em_last = 1'b1;
      end
      ftda_pkg::T_BAD: begin
        em_valid = 1'b1;
        em_last = 1'b1;
        em_bad = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    neg_nxt = neg_r;
    zero_nxt = zero_r;
    fix_nxt = fix_r;
    frac_nxt = frac_r;
    lead_nxt = lead_r;
    idx_nxt = idx_r;
    dlo_nxt = dlo_r;
    dhi_nxt = dhi_r;
    p_nxt = p_r;
    has_nxt = has_r;
    rup_nxt = rup_r;
    carry_nxt = carry_r;
    ie_nxt = ie_r;
    case (state_r)
      ftda_pkg::T_IDLE: begin
        if (accept) begin
          neg_nxt = in_value_bits[31];
          zero_nxt = (in_value_bits[30:0] == 31'd0);
          fix_nxt = style_r || (in_value_bits[30:0] == 31'd0);
          frac_nxt = frac_c;
          lead_nxt = ftda_pkg::DIG_LAST_IDX;
        end
      end
      ftda_pkg::T_GEN: begin
        if (dig_wr.we && dig_wr.data != 4'd0 && dig_wr.addr < lead_r) lead_nxt = dig_wr.addr;
      end
      ftda_pkg::T_PREP: begin
        dlo_nxt = fix_r ? lead_clip : lead_r;
        dhi_nxt = (fix_r ? ftda_pkg::INT_LAST_IDX : lead_r) + {2'd0, frac_r};
        idx_nxt = fix_r ? lead_clip : lead_r;
        has_nxt = 1'b0;
        p_nxt = 7'd0;
      end
      ftda_pkg::T_SCUSE: begin
        if (is_rnd) begin
          rup_nxt = rup_c;
          carry_nxt = carry_c;
          ie_nxt = ie_c;
          idx_nxt = dlo_r;
        end else begin
          if (rd_data_r != 4'd9) begin
            p_nxt = idx_r;
            has_nxt = 1'b1;
          end
          idx_nxt = idx_r + 7'd1;
        end
      end
      ftda_pkg::T_DIG: begin
        if (idx_r != pt && idx_r != dhi_r) idx_nxt = idx_r + 7'd1;
      end
      ftda_pkg::T_PT: begin
        if (idx_r != dhi_r) idx_nxt = idx_r + 7'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftda_pkg::T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= em_valid;
    end
    neg_r <= neg_nxt;
    zero_r <= zero_nxt;
    fix_r <= fix_nxt;
    frac_r <= frac_nxt;
    lead_r <= lead_nxt;
    idx_r <= idx_nxt;
    dlo_r <= dlo_nxt;
    dhi_r <= dhi_nxt;
    p_r <= p_nxt;
    has_r <= has_nxt;
    rup_r <= rup_nxt;
    carry_r <= carry_nxt;
    ie_r <= ie_nxt;
    out_char_r <= em_char;
    out_last_r <= em_last;
    out_bad_r <= em_bad;
  end

  assign out_valid = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;
  assign out_bad_value = out_bad_r;

  `FTDA_ASSERT_SAME(a_bad_is_last, out_valid && out_bad_value, out_last_char, "bad beat not last")
  `FTDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted value did not raise busy")
  `FTDA_ASSERT_SAME(a_wr_in_range, dig_wr.we, dig_wr.addr <= ftda_pkg::DIG_LAST_IDX,
                    "digit write out of range")

endmodule
